// ----- rtl/core/lpdp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpdp_pkg
// Shared widths, constants and types of the lidar point depth projection.
// ----------------------------------------------------------------------------
package lpdp_pkg;

	localparam int PIXEL_INDEX_BITS = 12;

	localparam int COORD_W  = 24;
	localparam int COEF_W   = 32;
	localparam int REG_W    = 64;
	localparam int SIZE_W   = 13;
	localparam int DEPTH_W  = 16;
	localparam int CFG_IDX_W = 3;

	// Datapath widths: product, row sum, divider numerator and trial divisor.
	localparam int PROD_W = COEF_W + COORD_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int NUM_W  = SUM_W + 1;
	localparam int EXT_W  = NUM_W + PIXEL_INDEX_BITS;
	localparam int CMP_W  = ((PIXEL_INDEX_BITS > SIZE_W) ? PIXEL_INDEX_BITS : SIZE_W) + 1;
	localparam int TRANS_SHIFT = 10;

	// Depth code: round(w * 800 / 2^26), saturated.
	localparam int DMUL_W      = 40;
	localparam int DSCALE_W    = 10;
	localparam int DPROD_W     = DMUL_W + DSCALE_W;
	localparam int ROUND_SHIFT = 26;
	localparam int DRND_W      = DPROD_W - ROUND_SHIFT;
	localparam logic [DSCALE_W-1:0] DEPTH_SCALE = DSCALE_W'(800);
	localparam logic [DPROD_W-1:0]  ROUND_HALF  = DPROD_W'(1) << (ROUND_SHIFT - 1);
	localparam logic [DEPTH_W-1:0]  DEPTH_MAX   = '1;

	// Forward range window, Q13.10 metres, both ends excluded.
	localparam logic signed [COORD_W-1:0] FWD_MIN = COORD_W'(5 * 1024);
	localparam logic signed [COORD_W-1:0] FWD_MAX = COORD_W'(80 * 1024);

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int DIV_STAGES = PIXEL_INDEX_BITS + 1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1242);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(375);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_AB = 3'd0,
		REG_ROW0_CD = 3'd1,
		REG_ROW1_AB = 3'd2,
		REG_ROW1_CD = 3'd3,
		REG_ROW2_AB = 3'd4,
		REG_ROW2_CD = 3'd5,
		REG_WIDTH   = 3'd6,
		REG_HEIGHT  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] fwd;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] up;
		logic                      frame_end;
		logic                      keep;
	} point_t;

	typedef struct packed {
		logic [2:0][REG_W-1:0] ab;
		logic [2:0][REG_W-1:0] cd;
		logic [SIZE_W-1:0]     width;
		logic [SIZE_W-1:0]     height;
	} cfg_t;

endpackage

// ----- rtl/core/lpdp_front.sv -----
// ----------------------------------------------------------------------------
// lpdp_front
// Accepts point beats, applies the forward range window and queues them.
// ----------------------------------------------------------------------------
module lpdp_front import lpdp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_fwd,
	input  logic signed [COORD_W-1:0] point_left,
	input  logic signed [COORD_W-1:0] point_up,
	input  logic                      frame_end,
	output logic                      q_valid,
	output point_t                    q_head,
	input  logic                      q_pop
);

	point_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	point_t            item;

	// Classify the incoming beat.
	always_comb begin
		item.fwd       = point_fwd;
		item.left      = point_left;
		item.up        = point_up;
		item.frame_end = frame_end;
		item.keep      = (point_fwd > FWD_MIN) && (point_fwd < FWD_MAX);
	end

	assign in_stall = (cnt_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_head   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/lpdp_div.sv -----
// ----------------------------------------------------------------------------
// lpdp_div
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module lpdp_div import lpdp_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NUM_W-1:0]            num,
	input  logic [NUM_W-1:0]            den,
	output logic [PIXEL_INDEX_BITS-1:0] quot,
	output logic                        ovf
);

	logic [NUM_W-1:0]            rem_s [DIV_STAGES];
	logic [NUM_W-1:0]            den_s [DIV_STAGES];
	logic [PIXEL_INDEX_BITS-1:0] quo_s [DIV_STAGES];
	logic                        ovf_s [DIV_STAGES];

	// First stage flags a quotient too large for the index width.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= ({{PIXEL_INDEX_BITS{1'b0}}, num} >=
				{den, {PIXEL_INDEX_BITS{1'b0}}});
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar i = 1; i < DIV_STAGES; i++) begin : g_stage
		localparam int B = PIXEL_INDEX_BITS - i;
		logic [EXT_W-1:0] trial;
		logic             take;

		assign trial = {{PIXEL_INDEX_BITS{1'b0}}, den_s[i-1]} << B;
		assign take  = ({{PIXEL_INDEX_BITS{1'b0}}, rem_s[i-1]} >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? (rem_s[i-1] - trial[NUM_W-1:0]) : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
				quo_s[i] <= quo_s[i-1] | (PIXEL_INDEX_BITS'(take) << B);
			end
		end
	end

	assign quot = quo_s[DIV_STAGES-1];
	assign ovf  = ovf_s[DIV_STAGES-1];

endmodule

// ----- rtl/core/lpdp_back.sv -----
// ----------------------------------------------------------------------------
// lpdp_back
// Projection, pixel division, depth code and the output register.
// ----------------------------------------------------------------------------
module lpdp_back import lpdp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        q_valid,
	input  point_t                      q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [PIXEL_INDEX_BITS-1:0] pixel_col,
	output logic [PIXEL_INDEX_BITS-1:0] pixel_row,
	output logic [DEPTH_W-1:0]          depth_code,
	output logic                        frame_end_out
);

	typedef struct packed {
		logic               ok;
		logic               neg_u;
		logic               neg_v;
		logic               fe;
		logic [DEPTH_W-1:0] code;
	} side_t;

	logic adv;

	logic                     valid_s1, keep_s1, fe_s1;
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [COEF_W-1:0] tr_s1 [3];

	logic                    valid_s2, keep_s2, fe_s2;
	logic signed [SUM_W-1:0] sum_s2 [3];

	logic               valid_s3, ok_s3, neg_u_s3, neg_v_s3, fe_s3, big_s3;
	logic [DPROD_W-1:0] dprod_s3;
	logic [NUM_W-1:0]   num_u_s3, num_v_s3, den_s3;

	logic                        sdv_q [DIV_STAGES];
	side_t                       sd_q  [DIV_STAGES];
	side_t                       sd_in;
	logic [DPROD_W-1:0]          drnd;
	logic [PIXEL_INDEX_BITS-1:0] quot_u, quot_v;
	logic                        ovf_u, ovf_v, col_ok, row_ok;

	logic                        out_valid_q, hit_q, fe_q;
	logic [PIXEL_INDEX_BITS-1:0] col_q, row_q;
	logic [DEPTH_W-1:0]          code_q;

	// The whole back pipeline moves unless a finished beat is held.
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	// Stage 1: the nine coefficient products.
	always_ff @(posedge clk) begin
		if (adv) begin
			keep_s1 <= q_head.keep;
			fe_s1   <= q_head.frame_end;
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= $signed(cfg.ab[r][COEF_W-1:0]) * q_head.fwd;
				prod_s1[r][1] <= $signed(cfg.ab[r][REG_W-1:COEF_W]) * q_head.left;
				prod_s1[r][2] <= $signed(cfg.cd[r][COEF_W-1:0]) * q_head.up;
				tr_s1[r]      <= $signed(cfg.cd[r][REG_W-1:COEF_W]);
			end
		end
	end

	// Stage 2: row sums u, v and w at Q.26.
	always_ff @(posedge clk) begin
		if (adv) begin
			keep_s2 <= keep_s1;
			fe_s2   <= fe_s1;
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1]) +
					SUM_W'(prod_s1[r][2]) + (SUM_W'(tr_s1[r]) <<< TRANS_SHIFT);
			end
		end
	end

	// Stage 3: depth check, rounding numerators and the depth product.
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3    <= keep_s2 && !sum_s2[2][SUM_W-1] && (sum_s2[2] != '0);
			neg_u_s3 <= sum_s2[0][SUM_W-1];
			neg_v_s3 <= sum_s2[1][SUM_W-1];
			fe_s3    <= fe_s2;
			num_u_s3 <= {(sum_s2[0][SUM_W-1] ? -sum_s2[0] : sum_s2[0]), 1'b0} +
				NUM_W'(unsigned'(sum_s2[2]));
			num_v_s3 <= {(sum_s2[1][SUM_W-1] ? -sum_s2[1] : sum_s2[1]), 1'b0} +
				NUM_W'(unsigned'(sum_s2[2]));
			den_s3   <= {sum_s2[2], 1'b0};
			big_s3   <= |sum_s2[2][SUM_W-1:DMUL_W];
			dprod_s3 <= sum_s2[2][DMUL_W-1:0] * DEPTH_SCALE;
		end
	end

	// Column and row dividers.
	lpdp_div u_div_col (
		.clk  (clk),
		.en   (adv),
		.num  (num_u_s3),
		.den  (den_s3),
		.quot (quot_u),
		.ovf  (ovf_u)
	);

	lpdp_div u_div_row (
		.clk  (clk),
		.en   (adv),
		.num  (num_v_s3),
		.den  (den_s3),
		.quot (quot_v),
		.ovf  (ovf_v)
	);

	// Rounded and saturated depth code, carried beside the dividers.
	assign drnd = dprod_s3 + ROUND_HALF;
	always_comb begin
		sd_in.ok    = ok_s3;
		sd_in.neg_u = neg_u_s3;
		sd_in.neg_v = neg_v_s3;
		sd_in.fe    = fe_s3;
		if (big_s3 || (drnd[DPROD_W-1:ROUND_SHIFT] > DRND_W'(DEPTH_MAX))) begin
			sd_in.code = DEPTH_MAX;
		end else begin
			sd_in.code = drnd[ROUND_SHIFT+DEPTH_W-1:ROUND_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= sd_in;
			for (int i = 1; i < DIV_STAGES; i++) begin
				sd_q[i] <= sd_q[i-1];
			end
		end
	end

	// Valid bits along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) begin
				sdv_q[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			sdv_q[0] <= valid_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				sdv_q[i] <= sdv_q[i-1];
			end
		end
	end

	// Index checks: no overflow, negative only when it rounds to zero, inside the image.
	assign col_ok = !ovf_u && (!sd_q[DIV_STAGES-1].neg_u || (quot_u == '0)) &&
		(CMP_W'(quot_u) < CMP_W'(cfg.width));
	assign row_ok = !ovf_v && (!sd_q[DIV_STAGES-1].neg_v || (quot_v == '0)) &&
		(CMP_W'(quot_v) < CMP_W'(cfg.height));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sdv_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= sd_q[DIV_STAGES-1].ok && col_ok && row_ok;
			fe_q   <= sd_q[DIV_STAGES-1].fe;
			col_q  <= (sd_q[DIV_STAGES-1].ok && col_ok && row_ok) ? quot_u : '0;
			row_q  <= (sd_q[DIV_STAGES-1].ok && col_ok && row_ok) ? quot_v : '0;
			code_q <= (sd_q[DIV_STAGES-1].ok && col_ok && row_ok) ?
				sd_q[DIV_STAGES-1].code : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign pixel_col     = col_q;
	assign pixel_row     = row_q;
	assign depth_code    = code_q;
	assign frame_end_out = fe_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (col_q == '0 && row_q == '0 && code_q == '0))
		else $error("missed point carries a non-zero payload");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s1) && $stable(valid_s3)))
		else $error("pipeline moved while the output was held");
`endif

endmodule

// ----- rtl/core/lidar_point_depth_projection.sv -----
// ----------------------------------------------------------------------------
// lidar_point_depth_projection
// Projects lidar points onto the camera image and gives a pixel depth write.
// ----------------------------------------------------------------------------
// Input channel: one beat per lidar point (forward, left, up in signed Q13.10
// metres, plus frame_end). A beat is taken when in_valid is high and in_stall
// is low. Output channel: exactly one beat per point, in order, taken when
// out_valid is high and out_stall is low; hit tells whether a pixel write is
// due, otherwise column, row and depth are zero. frame_end_out copies the
// input flag.
// Throughput is one point per cycle while the receiver does not stall. Between
// input beat and output beat lie the three projection stages, the
// one-bit-per-stage column and row dividers and the output register.
// A four-entry queue sits behind the input; in_stall rises only when it is
// full. While the receiver stalls, the back pipeline holds and the queue
// fills. Reset empties the pipeline, clears the coefficients and sets the
// image size to 1242 by 375. Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module lidar_point_depth_projection import lpdp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [REG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_W-1:0]   point_fwd,
	input  logic signed [COORD_W-1:0]   point_left,
	input  logic signed [COORD_W-1:0]   point_up,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [PIXEL_INDEX_BITS-1:0] pixel_col,
	output logic [PIXEL_INDEX_BITS-1:0] pixel_row,
	output logic [DEPTH_W-1:0]          depth_code,
	output logic                        frame_end_out
);

	cfg_t   cfg_q;
	logic   q_valid;
	logic   q_pop;
	point_t q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ab     <= '0;
			cfg_q.cd     <= '0;
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW0_AB: cfg_q.ab[0]  <= cfg_data;
				REG_ROW0_CD: cfg_q.cd[0]  <= cfg_data;
				REG_ROW1_AB: cfg_q.ab[1]  <= cfg_data;
				REG_ROW1_CD: cfg_q.cd[1]  <= cfg_data;
				REG_ROW2_AB: cfg_q.ab[2]  <= cfg_data;
				REG_ROW2_CD: cfg_q.cd[2]  <= cfg_data;
				REG_WIDTH:   cfg_q.width  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  cfg_q.height <= cfg_data[SIZE_W-1:0];
				default:     cfg_q        <= cfg_q;
			endcase
		end
	end

	lpdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_fwd  (point_fwd),
		.point_left (point_left),
		.point_up   (point_up),
		.frame_end  (frame_end),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	lpdp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.depth_code    (depth_code),
		.frame_end_out (frame_end_out)
	);

endmodule
